// ===== rtl/sis_pkg.sv =====
// shared types and constants for the sorted integer set unit
package sis_pkg;

    localparam int CAPACITY = 64;
    localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int VALUE_W  = 32;
    localparam int OP_W     = 2;
    localparam int COUNT_W  = 7;

    // request codes, any other code acts as a query
    localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_COMPARE,
        ST_CHECK,
        ST_MOVE_RD,
        ST_MOVE_WR,
        ST_RESULT
    } t_state;

    // memory port request from the controller
    typedef struct packed {
        logic               we;
        logic [ADDR_W-1:0]  waddr;
        logic [VALUE_W-1:0] wdata;
        logic [ADDR_W-1:0]  raddr;
    } t_ram_req;

    // finished result handed to the output register
    typedef struct packed {
        logic              was_present;
        logic              status;
        logic [CNT_W-1:0]  count;
    } t_result;

endpackage

// ===== rtl/sis_if.sv =====
// request and response channel interfaces

interface sis_req_if
    import sis_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic        [OP_W-1:0]    op;
    logic signed [VALUE_W-1:0] value;

    modport source (output valid, output op, output value, input ready);
    modport sink   (input valid, input op, input value, output ready);
endinterface

interface sis_rsp_if
    import sis_pkg::*;
;
    logic               valid;
    logic               ready;
    logic               was_present;
    logic               status;
    logic [COUNT_W-1:0] entry_count;

    modport source (output valid, output was_present, output status, output entry_count,
                    input ready);
    modport sink   (input valid, input was_present, input status, input entry_count,
                    output ready);
endinterface

// ===== rtl/sis_ram.sv =====
// generic single-clock ram, one write and one registered read port
module sis_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/sis_ctrl.sv =====
// search and shift sequencer working on the sorted entry memory
module sis_ctrl
    import sis_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    sis_req_if.sink            i_req,
    output t_ram_req           o_ram,
    input  logic [VALUE_W-1:0] i_rdata,
    output logic               o_res_valid,
    output t_result            o_res,
    input  logic               i_res_ready
);

    t_state r_state, n_state;

    logic [OP_W-1:0]           r_op,    n_op;
    logic signed [VALUE_W-1:0] r_value, n_value;
    logic [CNT_W-1:0]          r_lo,    n_lo;
    logic [CNT_W-1:0]          r_hi,    n_hi;
    logic [CNT_W-1:0]          r_mid,   n_mid;
    logic [CNT_W-1:0]          r_ptr,   n_ptr;
    logic [CNT_W-1:0]          r_count, n_count;
    logic                      r_hit,   n_hit;
    logic                      r_full,  n_full;

    logic              accept;
    logic [CNT_W-1:0]  mid;
    logic              search_done;
    logic              entry_below;
    logic              hit_now;
    logic              is_add;
    logic              is_remove;
    logic              move_more;
    logic [CNT_W-1:0]  ptr_up;
    logic [CNT_W-1:0]  ptr_down;

    // decoded request and search helpers
    assign accept      = i_req.valid && i_req.ready;
    assign mid         = r_lo + ((r_hi - r_lo) >> 1);
    assign search_done = (r_lo >= r_hi);
    assign entry_below = ($signed(i_rdata) < r_value);
    assign hit_now     = (r_lo < r_count) && ($signed(i_rdata) == r_value);
    assign is_add      = (r_op == OP_ADD);
    assign is_remove   = (r_op == OP_REMOVE);
    assign ptr_up      = r_ptr + 1'b1;
    assign ptr_down    = r_ptr - 1'b1;
    assign move_more   = is_add ? (r_ptr > r_lo) : (ptr_up < r_count);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) n_state = ST_SEARCH;
            end
            ST_SEARCH: begin
                n_state = search_done ? ST_CHECK : ST_COMPARE;
            end
            ST_COMPARE: begin
                n_state = ST_SEARCH;
            end
            ST_CHECK: begin
                if (is_add && !hit_now && (r_count < CNT_W'(CAPACITY))) begin
                    n_state = ST_MOVE_RD;
                end else if (is_remove && hit_now) begin
                    n_state = ST_MOVE_RD;
                end else begin
                    n_state = ST_RESULT;
                end
            end
            ST_MOVE_RD: begin
                n_state = move_more ? ST_MOVE_WR : ST_RESULT;
            end
            ST_MOVE_WR: begin
                n_state = ST_MOVE_RD;
            end
            ST_RESULT: begin
                if (i_res_ready) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath next values
    always_comb begin
        n_op    = r_op;
        n_value = r_value;
        n_lo    = r_lo;
        n_hi    = r_hi;
        n_mid   = r_mid;
        n_ptr   = r_ptr;
        n_count = r_count;
        n_hit   = r_hit;
        n_full  = r_full;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_op    = i_req.op;
                    n_value = i_req.value;
                    n_lo    = '0;
                    n_hi    = r_count;
                    n_hit   = 1'b0;
                    n_full  = 1'b0;
                end
            end
            ST_SEARCH: begin
                n_mid = mid;
            end
            ST_COMPARE: begin
                // lower bound step
                if (entry_below) begin
                    n_lo = r_mid + 1'b1;
                end else begin
                    n_hi = r_mid;
                end
            end
            ST_CHECK: begin
                n_hit  = hit_now;
                n_full = is_add && !hit_now && (r_count >= CNT_W'(CAPACITY));
                n_ptr  = is_add ? r_count : r_lo;
            end
            ST_MOVE_RD: begin
                if (!move_more) begin
                    n_count = is_add ? r_count + 1'b1 : r_count - 1'b1;
                end
            end
            ST_MOVE_WR: begin
                n_ptr = is_add ? ptr_down : ptr_up;
            end
            default: ;
        endcase
    end

    // outputs and memory requests
    always_comb begin
        i_req.ready = 1'b0;
        o_res_valid = 1'b0;
        o_ram.we    = 1'b0;
        o_ram.waddr = r_ptr[ADDR_W-1:0];
        o_ram.wdata = i_rdata;
        o_ram.raddr = r_lo[ADDR_W-1:0];
        unique case (r_state)
            ST_IDLE: begin
                i_req.ready = 1'b1;
            end
            ST_SEARCH: begin
                o_ram.raddr = search_done ? r_lo[ADDR_W-1:0] : mid[ADDR_W-1:0];
            end
            ST_COMPARE, ST_CHECK: ;
            ST_MOVE_RD: begin
                o_ram.raddr = is_add ? ptr_down[ADDR_W-1:0] : ptr_up[ADDR_W-1:0];
                // add ends by placing the new value at its slot
                if (is_add && !move_more) begin
                    o_ram.we    = 1'b1;
                    o_ram.waddr = r_lo[ADDR_W-1:0];
                    o_ram.wdata = r_value;
                end
            end
            ST_MOVE_WR: begin
                o_ram.we = 1'b1;
            end
            ST_RESULT: begin
                o_res_valid = 1'b1;
            end
            default: ;
        endcase
    end

    assign o_res.was_present = r_hit;
    assign o_res.status      = r_full;
    assign o_res.count       = r_count;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_op    <= n_op;
        r_value <= n_value;
        r_lo    <= n_lo;
        r_hi    <= n_hi;
        r_mid   <= n_mid;
        r_ptr   <= n_ptr;
        r_hit   <= n_hit;
        r_full  <= n_full;
    end

endmodule

// ===== rtl/sorted_integer_set_unit.sv =====
// top level of the sorted integer set unit
//
// Keeps up to CAPACITY distinct signed 32-bit members in ascending order in a
// single-port-read memory and serves one add, remove or query transaction at a
// time, each giving one response. A request runs a binary search over the
// members with a memory read, then a compare, per probe, then a final read
// and hit check, and then, for an add of a new value or a remove of a present
// one, moves each member that shifts by one slot with a read, then a write,
// and finishes. The response sits in an output register, so the next request
// is taken while it waits.
module sorted_integer_set_unit
    import sis_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    sis_req_if.sink   i_req,
    sis_rsp_if.source o_rsp
);

    t_ram_req           ram_req;
    logic [VALUE_W-1:0] ram_rdata;
    logic               res_valid;
    t_result            res;
    logic               res_ready;
    logic [31:0]        count_ext;

    logic               r_valid;
    logic               r_was_present;
    logic               r_status;
    logic [COUNT_W-1:0] r_entry_count;

    sis_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .o_ram       (ram_req),
        .i_rdata     (ram_rdata),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_ready (res_ready)
    );

    sis_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_waddr (ram_req.waddr),
        .i_wdata (ram_req.wdata),
        .i_raddr (ram_req.raddr),
        .o_rdata (ram_rdata)
    );

    // output register slot is free when empty or being drained
    assign res_ready = !r_valid || o_rsp.ready;
    assign count_ext = 32'(res.count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (res_ready) begin
            r_valid <= res_valid;
        end
    end

    // response payload
    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_was_present <= res.was_present;
            r_status      <= res.status;
            r_entry_count <= count_ext[COUNT_W-1:0];
        end
    end

    assign o_rsp.valid       = r_valid;
    assign o_rsp.was_present = r_was_present;
    assign o_rsp.status      = r_status;
    assign o_rsp.entry_count = r_entry_count;

endmodule

// ===== sim/tb_sorted_integer_set_unit.sv =====
// testbench for the sorted integer set unit: directed, fill, drain and random request checks
module tb_sorted_integer_set_unit;
    import sis_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // unnamed fourth code, handled by the block as a query
    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

    localparam logic signed [VALUE_W-1:0] INT_MIN = 32'sh8000_0000;
    localparam logic signed [VALUE_W-1:0] INT_MAX = 32'sh7FFF_FFFF;

    // receiver ready patterns
    localparam int READY_ALWAYS   = 0;
    localparam int READY_COIN     = 1;
    localparam int READY_SPARSE   = 2;
    localparam int READY_PERIODIC = 3;

    localparam int DRAIN_CYCLES = 200;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        logic               was_present;
        logic               status;
        logic [COUNT_W-1:0] entry_count;
    } t_set_outcome;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    sis_req_if req_if ();
    sis_rsp_if rsp_if ();

    sorted_integer_set_unit uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    always #2 clk = ~clk;

    // shadow copy of the set, kept in ascending signed order
    logic signed [VALUE_W-1:0] member_list[$];
    t_set_outcome              pending_outcomes[$];
    int                        error_count = 0;
    int                        burst_left = 0;

    // drive every input to a known value from time zero
    initial begin
        req_if.valid = 1'b0;
        req_if.op    = OP_QUERY;
        req_if.value = '0;
        rsp_if.ready = 1'b0;
    end

    // first slot whose member is not below the value
    function automatic int lower_slot(logic signed [VALUE_W-1:0] value);
        int slot;
        slot = 0;
        while (slot < member_list.size() && member_list[slot] < value) begin
            slot++;
        end
        return slot;
    endfunction

    function automatic bit is_member(logic signed [VALUE_W-1:0] value);
        int slot;
        slot = lower_slot(value);
        return slot < member_list.size() && member_list[slot] == value;
    endfunction

    // apply one request to the shadow set and give the outcome it must produce
    function automatic t_set_outcome apply_request(logic [OP_W-1:0] op,
                                                   logic signed [VALUE_W-1:0] value);
        t_set_outcome outcome;
        int           slot;
        bit           hit;
        slot = lower_slot(value);
        hit  = slot < member_list.size() && member_list[slot] == value;
        outcome.was_present = hit;
        outcome.status      = 1'b0;
        if (op == OP_ADD && !hit) begin
            if (member_list.size() >= CAPACITY) begin
                outcome.status = 1'b1;
            end else begin
                member_list.insert(slot, value);
            end
        end else if (op == OP_REMOVE && hit) begin
            member_list.delete(slot);
        end
        outcome.entry_count = COUNT_W'(member_list.size());
        return outcome;
    endfunction

    // one request transaction, then the sender's burst and gap pacing
    task automatic send_request(input logic [OP_W-1:0] op,
                                input logic signed [VALUE_W-1:0] value);
        int gap;
        @(negedge clk);
        req_if.valid = 1'b1;
        req_if.op    = op;
        req_if.value = value;
        do @(posedge clk); while (!req_if.ready);
        pending_outcomes.push_back(apply_request(op, value));
        if (burst_left > 0) begin
            burst_left--;
        end
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                @(negedge clk);
                req_if.valid = 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
    endtask

    // value that is not yet in the set
    function automatic logic signed [VALUE_W-1:0] fresh_value();
        logic signed [VALUE_W-1:0] value;
        do value = $urandom; while (is_member(value));
        return value;
    endfunction

    // mix of present members, small clustered values, extremes and wide values
    function automatic logic signed [VALUE_W-1:0] pick_value();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 40 && member_list.size() > 0) begin
            return member_list[$urandom_range(0, member_list.size() - 1)];
        end else if (pick < 60) begin
            return VALUE_W'($signed($urandom_range(0, 32)) - 16);
        end else if (pick < 70) begin
            if ($urandom_range(0, 1) == 0) begin
                return INT_MIN + VALUE_W'($urandom_range(0, 3));
            end else begin
                return INT_MAX - VALUE_W'($urandom_range(0, 3));
            end
        end
        return $urandom;
    endfunction

    // extremes, duplicates, absent removes and the spare op code
    task automatic test_directed();
        send_request(OP_QUERY, 32'sd0);
        send_request(OP_REMOVE, 32'sd5);
        send_request(OP_ADD, INT_MIN);
        send_request(OP_ADD, INT_MAX);
        send_request(OP_ADD, 32'sd0);
        send_request(OP_ADD, -32'sd1);
        send_request(OP_ADD, 32'sd1);
        send_request(OP_ADD, 32'sd0);
        send_request(OP_QUERY, INT_MIN);
        send_request(OP_QUERY, INT_MAX);
        send_request(OP_QUERY, 32'sd2);
        send_request(OP_SPARE, -32'sd1);
        send_request(OP_SPARE, 32'sd12345);
        send_request(OP_REMOVE, INT_MAX);
        send_request(OP_REMOVE, 32'sd0);
        send_request(OP_REMOVE, 32'sd0);
        send_request(OP_REMOVE, INT_MIN);
        send_request(OP_ADD, 32'sh5555_5555);
        send_request(OP_ADD, 32'shAAAA_AAAA);
        send_request(OP_REMOVE, -32'sd1);
        send_request(OP_REMOVE, 32'sd1);
        send_request(OP_REMOVE, 32'sh5555_5555);
        send_request(OP_REMOVE, 32'shAAAA_AAAA);
        send_request(OP_QUERY, 32'shAAAA_AAAA);
    endtask

    // fill to capacity, then adds that must be dropped or are duplicates, with a query, spare code and remove mixed in
    task automatic test_fill_and_overflow();
        logic signed [VALUE_W-1:0] member;
        while (member_list.size() < CAPACITY) begin
            send_request(OP_ADD, fresh_value());
        end
        if (!is_member(INT_MIN)) send_request(OP_ADD, INT_MIN);
        if (!is_member(INT_MAX)) send_request(OP_ADD, INT_MAX);
        repeat (4) send_request(OP_ADD, fresh_value());
        member = member_list[$urandom_range(0, CAPACITY - 1)];
        send_request(OP_ADD, member);
        send_request(OP_QUERY, member);
        send_request(OP_SPARE, member_list[0]);
        send_request(OP_REMOVE, member);
        send_request(OP_ADD, member);
        send_request(OP_ADD, fresh_value());
    endtask

    // remove every member in random order, with absent lookups mixed in
    task automatic test_drain_in_random_order();
        while (member_list.size() > 0) begin
            if ($urandom_range(0, 7) == 0) begin
                send_request($urandom_range(0, 1) ? OP_QUERY : OP_REMOVE, fresh_value());
            end
            send_request(OP_REMOVE, member_list[$urandom_range(0, member_list.size() - 1)]);
        end
        send_request(OP_REMOVE, INT_MIN);
    endtask

    // alternating grow and shrink phases so the count sweeps its range
    task automatic test_random_mix();
        int                  pick;
        bit                  grow;
        logic [OP_W-1:0]     op;
        for (int phase = 0; phase < 8; phase++) begin
            grow = (phase % 2) == 0;
            repeat (100) begin
                pick = $urandom_range(0, 99);
                if (pick < (grow ? 60 : 25)) begin
                    op = OP_ADD;
                end else if (pick < 80) begin
                    op = OP_REMOVE;
                end else if (pick < 96) begin
                    op = OP_QUERY;
                end else begin
                    op = OP_SPARE;
                end
                send_request(op, pick_value());
            end
        end
    endtask

    // response checker against the oldest expectation
    t_set_outcome expected_outcome;
    always @(posedge clk) begin
        if (rst_n && rsp_if.valid && rsp_if.ready) begin
            if (pending_outcomes.size() == 0) begin
                error_count++;
                if (error_count <= MAX_REPORTS) begin
                    $display("unexpected response: was_present=%0b status=%0b count=%0d",
                             rsp_if.was_present, rsp_if.status, rsp_if.entry_count);
                end
            end else begin
                expected_outcome = pending_outcomes.pop_front();
                if (rsp_if.was_present !== expected_outcome.was_present ||
                    rsp_if.status !== expected_outcome.status ||
                    rsp_if.entry_count !== expected_outcome.entry_count) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS) begin
                        $display({"mismatch at %0t: was_present %0b/%0b",
                                  " status %0b/%0b count %0d/%0d"},
                                 $realtime, expected_outcome.was_present, rsp_if.was_present,
                                 expected_outcome.status, rsp_if.status,
                                 expected_outcome.entry_count, rsp_if.entry_count);
                    end
                end
            end
        end
    end

    // receiver ready on patterns of its own
    initial begin : ready_pattern
        int mode;
        int span;
        @(posedge rst_n);
        forever begin
            mode = $urandom_range(READY_ALWAYS, READY_PERIODIC);
            span = $urandom_range(20, 150);
            for (int step = 0; step < span; step++) begin
                @(negedge clk);
                case (mode)
                    READY_ALWAYS: begin
                        rsp_if.ready = 1'b1;
                    end
                    READY_COIN: begin
                        rsp_if.ready = $urandom_range(0, 1);
                    end
                    READY_SPARSE: begin
                        rsp_if.ready = $urandom_range(0, 3) == 0;
                    end
                    default: begin
                        rsp_if.ready = (step % 7) < 3;
                    end
                endcase
            end
        end
    end

    // sequence of tests, then drain and verdict
    initial begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_fill_and_overflow();
        test_drain_in_random_order();
        test_random_mix();
        @(negedge clk);
        req_if.valid = 1'b0;
        while (pending_outcomes.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // hang guard
    initial begin
        #4_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
